[rtl/like_wildcard_matcher_top_assert.svh]
// assertion macros used by the checker file
`ifndef LIKE_WILDCARD_MATCHER_TOP_ASSERT_SVH
`define LIKE_WILDCARD_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_pkg
// Constants and the token type that travels along the matcher cell chain.
// ----------------------------------------------------------------------------
package lwm_pkg;

  localparam int DEF_PATTERN_LEN = 64;

  localparam logic [7:0] ANY_RUN = 8'd37;  // '%'
  localparam logic [7:0] ANY_ONE = 8'd95;  // '_'

  // one token per accepted transaction; the *_nb fields describe the
  // cell that handed the token on
  typedef struct packed {
    logic       vld;
    logic       is_text;
    logic       clr;        // new pattern: drop every stored byte
    logic       wr;         // pattern byte write
    logic       fresh;      // first transaction of a text
    logic       present;
    logic       last;
    logic       ovf;
    logic [7:0] data;
    logic       v_nb;
    logic [7:0] s_nb;
    logic       a0_nb;      // neighbour active at text start
    logic       a_nb;       // neighbour active after this byte
    logic       a_prev_nb;  // neighbour active before this byte
    logic       hit;        // end position reached
  } tok_t;

endpackage

[rtl/lwm_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_in_if
// Input channel: pattern or text bytes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lwm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, mode, data_byte, byte_present, is_last, input ready);
  modport sink   (input valid, mode, data_byte, byte_present, is_last, output ready);
  modport mon    (input valid, ready, mode, data_byte, byte_present, is_last);
endinterface

[rtl/lwm_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_out_if
// Output channel: one match result per text, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink   (input valid, matched, pattern_overflow, output ready);
  modport mon    (input valid, ready, matched, pattern_overflow);
endinterface

[rtl/lwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_front
// Pattern bookkeeping and token injection at the head of the cell chain.
// ----------------------------------------------------------------------------
module lwm_front #(
  parameter int PATTERN_LEN = lwm_pkg::DEF_PATTERN_LEN,
  parameter int IW          = $clog2(PATTERN_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  lwm_in_if.sink        in_ch,
  output lwm_pkg::tok_t tok,
  output logic [IW-1:0] idx
);
  import lwm_pkg::*;

  logic [IW-1:0] pat_len, pat_len_next;
  logic          pat_done, pat_done_next;
  logic          ovf, ovf_next;
  logic          fresh, fresh_next;
  logic          fire;
  logic [IW-1:0] len_base;
  logic          ovf_base;
  logic          room;

  assign in_ch.ready = adv;
  assign fire        = in_ch.valid && adv;

  always_comb begin
    len_base      = pat_done ? '0 : pat_len;
    ovf_base      = pat_done ? 1'b0 : ovf;
    room          = len_base < IW'(PATTERN_LEN);
    pat_len_next  = pat_len;
    pat_done_next = pat_done;
    ovf_next      = ovf;
    fresh_next    = fresh;

    tok           = '0;
    tok.vld       = fire;
    tok.is_text   = in_ch.mode;
    tok.clr       = !in_ch.mode && pat_done;
    tok.wr        = !in_ch.mode && in_ch.byte_present && room;
    tok.fresh     = fresh;
    tok.present   = in_ch.byte_present;
    tok.last      = in_ch.is_last;
    tok.ovf       = ovf;
    tok.data      = in_ch.data_byte;
    // virtual cell ahead of position zero: a '%' that is active only at start
    tok.v_nb      = 1'b1;
    tok.s_nb      = ANY_RUN;
    tok.a0_nb     = 1'b1;
    tok.a_nb      = 1'b0;
    tok.a_prev_nb = 1'b0;
    tok.hit       = 1'b0;
    idx           = len_base;

    if (fire) begin
      if (!in_ch.mode) begin
        pat_len_next = len_base;
        ovf_next     = ovf_base;
        if (in_ch.byte_present) begin
          if (room) begin
            pat_len_next = len_base + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
        pat_done_next = in_ch.is_last;
        fresh_next    = 1'b1;
      end else begin
        fresh_next = in_ch.is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len  <= '0;
      pat_done <= 1'b1;
      ovf      <= 1'b0;
      fresh    <= 1'b1;
    end else begin
      pat_len  <= pat_len_next;
      pat_done <= pat_done_next;
      ovf      <= ovf_next;
      fresh    <= fresh_next;
    end
  end

endmodule

[rtl/lwm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_cell
// One pattern position: holds its byte and active bit, updates both as
// tokens pass and hands each token on to the next position through a register.
// ----------------------------------------------------------------------------
module lwm_cell #(
  parameter int PATTERN_LEN = lwm_pkg::DEF_PATTERN_LEN,
  parameter int CELL_ID     = 0,
  parameter int IW          = $clog2(PATTERN_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  lwm_pkg::tok_t tok_in,
  input  logic [IW-1:0] idx_in,
  output lwm_pkg::tok_t tok_out,
  output logic [IW-1:0] idx_out
);
  import lwm_pkg::*;

  tok_t       tok_q, tok_next;
  logic [7:0] s_q;
  logic       v_q;
  logic       a_q;
  logic       pct_nb, pct_self, a0_self, cur_self, cur_nb, step, a_new;

  always_comb begin
    pct_nb   = tok_in.v_nb && (tok_in.s_nb == ANY_RUN);
    pct_self = v_q && (s_q == ANY_RUN);
    a0_self  = pct_nb && tok_in.a0_nb;
    cur_self = tok_in.fresh ? a0_self : a_q;
    cur_nb   = tok_in.fresh ? tok_in.a0_nb : tok_in.a_prev_nb;
    // neighbour consumes this byte and moves on to us
    step     = cur_nb && tok_in.v_nb && (tok_in.s_nb != ANY_RUN)
               && ((tok_in.s_nb == ANY_ONE) || (tok_in.s_nb == tok_in.data));
    a_new    = tok_in.present ? ((cur_self && pct_self) || step || (pct_nb && tok_in.a_nb))
                              : cur_self;

    tok_next           = tok_in;
    tok_next.v_nb      = v_q;
    tok_next.s_nb      = s_q;
    tok_next.a0_nb     = a0_self;
    tok_next.a_nb      = a_new;
    tok_next.a_prev_nb = a_q;
    tok_next.hit       = tok_in.hit || (a_new && !v_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
      v_q   <= 1'b0;
      a_q   <= 1'b0;
    end else if (adv) begin
      tok_q <= tok_next;
      if (tok_in.vld) begin
        if (tok_in.is_text) begin
          a_q <= a_new;
        end else begin
          if (tok_in.clr) begin
            v_q <= 1'b0;
          end
          if (tok_in.wr && (idx_in == IW'(CELL_ID))) begin
            v_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_out <= idx_in;
      if (tok_in.vld && !tok_in.is_text && tok_in.wr && (idx_in == IW'(CELL_ID))) begin
        s_q <= tok_in.data;
      end
    end
  end

  assign tok_out = tok_q;

endmodule

[rtl/like_wildcard_matcher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// like_wildcard_matcher_top
// LIKE-style wildcard matcher: '%' any run, '_' any one byte.
// ----------------------------------------------------------------------------
// in_ch carries pattern transactions (mode 0) and text transactions (mode 1),
// one byte each; byte_present low lets a pattern or text be empty and is_last
// closes it. A pattern transaction while the previous pattern is complete
// starts a new pattern. out_ch gives one transaction per text, on its last
// transaction: matched and pattern_overflow.
// Every transaction travels down a row of PATTERN_LEN + 1 position cells,
// one cell on each time the chain advances; a text's result is loaded into
// the output register as its last transaction leaves. One transaction is taken
// every cycle unless the chain stalls, as each cell updates while it registers.
// Reset leaves an empty, complete pattern and no text in progress.
// When the receiver stalls with a result held, the chain stops only once a
// second result reaches its end; in_ch.ready then drops until out_ch drains.
// ----------------------------------------------------------------------------
module like_wildcard_matcher_top #(
  parameter int PATTERN_LEN = lwm_pkg::DEF_PATTERN_LEN
) (
  input  logic     clk,
  input  logic     rst,
  lwm_in_if.sink   in_ch,
  lwm_out_if.source out_ch
);
  import lwm_pkg::*;

  localparam int IW = $clog2(PATTERN_LEN + 1);

  tok_t          tok [0:PATTERN_LEN+1];
  logic [IW-1:0] idx [0:PATTERN_LEN+1];
  logic          adv;
  logic          tail_res;
  logic          out_valid;
  logic          out_matched;
  logic          out_ovf;

  assign tail_res = tok[PATTERN_LEN+1].vld && tok[PATTERN_LEN+1].is_text
                    && tok[PATTERN_LEN+1].last;
  assign adv      = !(tail_res && out_valid && !out_ch.ready);

  lwm_front #(
    .PATTERN_LEN (PATTERN_LEN),
    .IW          (IW)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .in_ch (in_ch),
    .tok   (tok[0]),
    .idx   (idx[0])
  );

  for (genvar g = 0; g <= PATTERN_LEN; g++) begin : g_cell
    lwm_cell #(
      .PATTERN_LEN (PATTERN_LEN),
      .CELL_ID     (g),
      .IW          (IW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  // output register, loaded when a last text transaction leaves the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && tail_res) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_res) begin
      out_matched <= tok[PATTERN_LEN+1].hit && !tok[PATTERN_LEN+1].ovf;
      out_ovf     <= tok[PATTERN_LEN+1].ovf;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.matched          = out_matched;
  assign out_ch.pattern_overflow = out_ovf;

endmodule

[rtl/lwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_checker
// Port-level checks on the wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "like_wildcard_matcher_top_assert.svh"

module lwm_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic matched,
  input logic pattern_overflow
);

  // a held result keeps its payload
  `LWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(matched) && $stable(pattern_overflow), "result changed while stalled")

  // an overflowed pattern never matches
  `LWM_ASSERT_SAME(a_ovf_nomatch, out_valid && pattern_overflow, !matched, "match reported on overflowed pattern")

  // with no result waiting the input side is never held off
  `LWM_ASSERT_SAME(a_ready_free, !out_valid, in_ready, "input stalled with empty output")

  // no result straight out of reset
  `LWM_ASSERT_SAME(a_rst_quiet, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind like_wildcard_matcher_top lwm_checker u_lwm_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .matched          (out_ch.matched),
  .pattern_overflow (out_ch.pattern_overflow)
);
